### src/rwt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwt_pkg
// Shared codes and controller/datapath interface types of the receive
// window tracker.
// ----------------------------------------------------------------------------
package rwt_pkg;

  localparam logic [1:0] CK_ORDERED   = 2'd0;
  localparam logic [1:0] CK_UNORDERED = 2'd1;
  localparam logic [1:0] CK_UNRELIABLE = 2'd2;
  localparam logic [1:0] CK_MONOTONIC = 2'd3;

  localparam logic [2:0] CT_NONE   = 3'd0;
  localparam logic [2:0] CT_SYN    = 3'd1;
  localparam logic [2:0] CT_SYNACK = 3'd2;
  localparam logic [2:0] CT_ACK    = 3'd3;
  localparam logic [2:0] CT_FIN    = 3'd4;

  localparam logic ITEM_STATUS = 1'b0;
  localparam logic ITEM_EVENT  = 1'b1;

  typedef enum logic [1:0] {
    ROUTE_NONE,
    ROUTE_ORD,
    ROUTE_EV,
    ROUTE_VER
  } route_e;

  typedef struct packed {
    logic accept;
    logic slot_write;
    logic drain_rd;
    logic drain_take;
    logic ver_rd;
    logic ver_take;
    logic ev_take;
    logic fin_take;
  } cmd_t;

  typedef struct packed {
    route_e route;
    logic   smod_done;
    logic   cmod_done;
    logic   hit;
    logic   newer;
    logic   out_free;
  } sts_t;

endpackage

### src/reliable_udp_rx_window_tracker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reliable_udp_rx_window_tracker_top
// Receive window tracker: cumulative front with duplicate bitmap, ordered
// reorder store and per-channel version filter.
// ----------------------------------------------------------------------------
// One packet header is taken per beat while the block is idle. It answers with
// a status beat (ack request) followed by the data beats the packet releases;
// last_of_run marks the final beat. The window update is done in the accept
// cycle. Reliable ordered packets then compute the slot index (a three-stage
// reciprocal remainder unit), read and check the reorder RAM for each released
// event, stop the drain and send the closing beat; monotonic packets compute
// the channel index (its completion issues the version RAM read), then do the
// compare and send the closing beat; other packets send their event beat, if
// any, and the closing beat. Each result beat needs a free output register.
// No clearing pass is needed after reset.
module reliable_udp_rx_window_tracker_top #(
  parameter int ACK_WINDOW    = 32,
  parameter int REORDER_SLOTS = 64,
  parameter int CHANNELS      = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] pkt_seq_i,
  input  logic [1:0]  chan_kind_i,
  input  logic [2:0]  ctrl_kind_i,
  input  logic [7:0]  chan_id_i,
  input  logic [15:0] payload_ref_i,
  input  logic        has_version_i,
  input  logic [31:0] version_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        item_kind_o,
  output logic        ack_request_o,
  output logic [31:0] event_seq_o,
  output logic [7:0]  event_chan_id_o,
  output logic [1:0]  event_chan_kind_o,
  output logic [15:0] event_payload_ref_o,
  output logic        last_of_run_o
);

  import rwt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rwt_ctrl #(.ACK_WINDOW(ACK_WINDOW)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rwt_dp #(
    .ACK_WINDOW    (ACK_WINDOW),
    .REORDER_SLOTS (REORDER_SLOTS),
    .CHANNELS      (CHANNELS)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .pkt_seq_i           (pkt_seq_i),
    .chan_kind_i         (chan_kind_i),
    .ctrl_kind_i         (ctrl_kind_i),
    .chan_id_i           (chan_id_i),
    .payload_ref_i       (payload_ref_i),
    .has_version_i       (has_version_i),
    .version_word_i      (version_word_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .item_kind_o         (item_kind_o),
    .ack_request_o       (ack_request_o),
    .event_seq_o         (event_seq_o),
    .event_chan_id_o     (event_chan_id_o),
    .event_chan_kind_o   (event_chan_kind_o),
    .event_payload_ref_o (event_payload_ref_o),
    .last_of_run_o       (last_of_run_o)
  );

endmodule

### src/rwt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwt_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module rwt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/rwt_mod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwt_mod
// Remainder of a 32-bit value by a constant, in order: a 16-bit fold,
// a reciprocal multiply for the quotient and a back-multiply and subtract.
// ----------------------------------------------------------------------------
module rwt_mod #(
  parameter int MOD = 64
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic [31:0]                           value_i,
  output logic                                  done_o,
  output logic [(MOD > 1 ? $clog2(MOD) : 1)-1:0] rem_o
);

  localparam int          RW    = (MOD > 1) ? $clog2(MOD) : 1;
  localparam int          LG    = (MOD > 1) ? $clog2(MOD) : 0;
  localparam int          SH    = 25 + LG;
  localparam logic [25:0] RECIP = 26'(((64'd1 << SH) + 64'(MOD) - 64'd1) / 64'(MOD));
  localparam logic [7:0]  C16   = 8'(65536 % MOD);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [1:0]    ph_q, ph_d;
  logic [31:0]   val_q, val_d;
  logic [24:0]   y_q, y_d;
  logic [24:0]   quo_q, quo_d;
  logic [RW-1:0] rem_q, rem_d;
  logic [50:0]   prod;

  always_comb begin
    prod   = {26'd0, y_q} * {25'd0, RECIP};
    busy_d = busy_q;
    done_d = done_q;
    ph_d   = ph_q;
    val_d  = val_q;
    y_d    = y_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      ph_d   = 2'd0;
      val_d  = value_i;
    end else if (busy_q) begin
      ph_d = ph_q + 2'd1;
      unique case (ph_q)
        2'd0: y_d = ({9'd0, val_q[31:16]} * {17'd0, C16}) + {9'd0, val_q[15:0]};
        2'd1: quo_d = 25'(prod >> SH);
        default: begin
          rem_d  = RW'(y_q - (quo_q * 25'(MOD)));
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      ph_q   <= 2'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      ph_q   <= ph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    y_q   <= y_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

### src/rwt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwt_ctrl
// Sequencer of one packet: window update, reorder drain, version check and
// result beats.
// ----------------------------------------------------------------------------
module rwt_ctrl #(
  parameter int ACK_WINDOW = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  rwt_pkg::sts_t sts_i,
  output rwt_pkg::cmd_t cmd_o
);

  import rwt_pkg::*;

  localparam int LW = $clog2(ACK_WINDOW + 2);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SMOD,
    S_DRD,
    S_DCHK,
    S_CMOD,
    S_VCHK,
    S_EV,
    S_FIN
  } state_e;

  state_e        state_q;
  logic [LW-1:0] limit_q;
  cmd_t          cmd;

  always_comb begin
    cmd = '0;
    unique case (state_q)
      S_IDLE: cmd.accept     = in_valid_i;
      S_SMOD: cmd.slot_write = sts_i.smod_done;
      S_DRD:  cmd.drain_rd   = (limit_q != '0);
      S_DCHK: cmd.drain_take = sts_i.hit && sts_i.out_free;
      S_CMOD: cmd.ver_rd     = sts_i.cmod_done;
      S_VCHK: cmd.ver_take   = sts_i.newer && sts_i.out_free;
      S_EV:   cmd.ev_take    = sts_i.out_free;
      S_FIN:  cmd.fin_take   = sts_i.out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      limit_q <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            unique case (sts_i.route)
              ROUTE_ORD:  state_q <= S_SMOD;
              ROUTE_EV:   state_q <= S_EV;
              ROUTE_VER:  state_q <= S_CMOD;
              ROUTE_NONE: state_q <= S_FIN;
              default:    state_q <= S_FIN;
            endcase
          end
        end
        S_SMOD: begin
          if (sts_i.smod_done) begin
            limit_q <= LW'(ACK_WINDOW + 1);
            state_q <= S_DRD;
          end
        end
        S_DRD: state_q <= (limit_q != '0) ? S_DCHK : S_FIN;
        S_DCHK: begin
          if (!sts_i.hit) begin
            state_q <= S_FIN;
          end else if (sts_i.out_free) begin
            limit_q <= limit_q - LW'(1);
            state_q <= S_DRD;
          end
        end
        S_CMOD: if (sts_i.cmod_done) state_q <= S_VCHK;
        S_VCHK: begin
          if (!sts_i.newer || sts_i.out_free) begin
            state_q <= S_FIN;
          end
        end
        S_EV:  if (sts_i.out_free) state_q <= S_FIN;
        S_FIN: if (sts_i.out_free) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign cmd_o      = cmd;

endmodule

### src/rwt_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwt_dp
// Datapath: receive front and bitmap, reorder store, version table,
// pending result and output register.
// ----------------------------------------------------------------------------
module rwt_dp #(
  parameter int ACK_WINDOW    = 32,
  parameter int REORDER_SLOTS = 64,
  parameter int CHANNELS      = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rwt_pkg::cmd_t cmd_i,
  output rwt_pkg::sts_t sts_o,
  input  logic [31:0]   pkt_seq_i,
  input  logic [1:0]    chan_kind_i,
  input  logic [2:0]    ctrl_kind_i,
  input  logic [7:0]    chan_id_i,
  input  logic [15:0]   payload_ref_i,
  input  logic          has_version_i,
  input  logic [31:0]   version_word_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic          item_kind_o,
  output logic          ack_request_o,
  output logic [31:0]   event_seq_o,
  output logic [7:0]    event_chan_id_o,
  output logic [1:0]    event_chan_kind_o,
  output logic [15:0]   event_payload_ref_o,
  output logic          last_of_run_o
);

  import rwt_pkg::*;

  localparam int SAW = (REORDER_SLOTS > 1) ? $clog2(REORDER_SLOTS) : 1;
  localparam int CAW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int TW  = $clog2(ACK_WINDOW + 2);
  localparam int EW  = 56;

  logic [31:0]             front_q, front_d;
  logic [ACK_WINDOW-1:0]   bitmap_q, bitmap_d;
  logic                    started_q;
  logic [31:0]             onext_q;
  logic [SAW-1:0]          oidx_q;
  logic [REORDER_SLOTS-1:0] slot_valid_q;
  logic [CHANNELS-1:0]     ver_valid_q;
  logic                    out_valid_q;

  logic [31:0] it_seq_q;
  logic [7:0]  it_chan_q;
  logic [15:0] it_ref_q;
  logic [31:0] it_ver_q;
  logic [1:0]  it_kind_q;

  logic        pend_kind_q, pend_ack_q;
  logic [31:0] pend_seq_q;
  logic [7:0]  pend_chan_q;
  logic [1:0]  pend_ckind_q;
  logic [15:0] pend_ref_q;

  logic        out_kind_q, out_ack_q, out_last_q;
  logic [31:0] out_seq_q;
  logic [7:0]  out_chan_q;
  logic [1:0]  out_ckind_q;
  logic [15:0] out_ref_q;

  logic                  reliable, gated, process, ack;
  logic [31:0]           front_eff, delta;
  logic [TW-1:0]         tcnt, adv;
  logic [ACK_WINDOW-1:0] bit_mask;
  route_e                route;

  logic           smod_done, cmod_done;
  logic [SAW-1:0] srem;
  logic [CAW-1:0] crem;
  logic [EW-1:0]  slot_rdata;
  logic [31:0]    ver_rdata, vdiff;
  logic           push, take, hit, newer, out_free;

  // window update
  always_comb begin
    reliable  = (chan_kind_i == CK_ORDERED) || (chan_kind_i == CK_UNORDERED);
    gated     = reliable || (ctrl_kind_i == CT_SYN) || (ctrl_kind_i == CT_SYNACK) ||
                (ctrl_kind_i == CT_ACK) || (ctrl_kind_i == CT_FIN);
    front_eff = (front_q == 32'd0) ? pkt_seq_i : front_q;
    delta     = pkt_seq_i - front_eff;
    tcnt      = TW'(ACK_WINDOW);
    for (int i = ACK_WINDOW - 1; i >= 0; i--) begin
      if (!bitmap_q[i]) tcnt = TW'(i);
    end
    adv       = tcnt + TW'(1);
    bit_mask  = ACK_WINDOW'(1) << (delta - 32'd1);
    front_d   = front_q;
    bitmap_d  = bitmap_q;
    process   = 1'b1;
    ack       = 1'b0;
    if (gated) begin
      ack     = reliable || (ctrl_kind_i == CT_FIN);
      front_d = front_eff;
      if (pkt_seq_i == front_eff) begin
        front_d  = front_eff + 32'(adv);
        bitmap_d = bitmap_q >> adv;
      end else if (!delta[31] && (delta <= 32'(ACK_WINDOW))) begin
        process  = ((bitmap_q & bit_mask) == '0);
        bitmap_d = bitmap_q | bit_mask;
      end else begin
        process  = 1'b0;
      end
    end
    route = ROUTE_NONE;
    if ((ctrl_kind_i == CT_NONE) && process) begin
      unique case (chan_kind_i)
        CK_ORDERED:    route = ROUTE_ORD;
        CK_UNORDERED:  route = ROUTE_EV;
        CK_UNRELIABLE: route = ROUTE_EV;
        CK_MONOTONIC:  route = has_version_i ? ROUTE_VER : ROUTE_NONE;
        default:       route = ROUTE_NONE;
      endcase
    end
  end

  rwt_mod #(.MOD(REORDER_SLOTS)) u_smod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.accept && (route == ROUTE_ORD)),
    .value_i (pkt_seq_i),
    .done_o  (smod_done),
    .rem_o   (srem)
  );

  rwt_mod #(.MOD(CHANNELS)) u_cmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.accept && (route == ROUTE_VER)),
    .value_i (32'(chan_id_i)),
    .done_o  (cmod_done),
    .rem_o   (crem)
  );

  rwt_ram #(.WIDTH(EW), .DEPTH(REORDER_SLOTS)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.slot_write),
    .waddr_i (srem),
    .wdata_i ({it_seq_q, it_chan_q, it_ref_q}),
    .re_i    (cmd_i.drain_rd),
    .raddr_i (oidx_q),
    .rdata_o (slot_rdata)
  );

  rwt_ram #(.WIDTH(32), .DEPTH(CHANNELS)) u_ver_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ver_take),
    .waddr_i (crem),
    .wdata_i (it_ver_q),
    .re_i    (cmd_i.ver_rd),
    .raddr_i (crem),
    .rdata_o (ver_rdata)
  );

  assign hit      = slot_valid_q[oidx_q] && (slot_rdata[55:24] == onext_q);
  assign vdiff    = it_ver_q - ver_rdata;
  assign newer    = !ver_valid_q[crem] || ((vdiff != 32'd0) && !vdiff[31]);
  assign out_free = !out_valid_q || !out_stall_i;
  assign take     = cmd_i.drain_take || cmd_i.ver_take || cmd_i.ev_take;
  assign push     = take || cmd_i.fin_take;

  always_comb begin
    sts_o.route     = route;
    sts_o.smod_done = smod_done;
    sts_o.cmod_done = cmod_done;
    sts_o.hit       = hit;
    sts_o.newer     = newer;
    sts_o.out_free  = out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q      <= 32'd0;
      bitmap_q     <= '0;
      started_q    <= 1'b0;
      onext_q      <= 32'd0;
      oidx_q       <= '0;
      slot_valid_q <= '0;
      ver_valid_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        front_q  <= front_d;
        bitmap_q <= bitmap_d;
      end
      if (cmd_i.slot_write) begin
        slot_valid_q[srem] <= 1'b1;
        if (!started_q) begin
          started_q <= 1'b1;
          onext_q   <= it_seq_q;
          oidx_q    <= srem;
        end
      end
      if (cmd_i.drain_take) begin
        slot_valid_q[oidx_q] <= 1'b0;
        onext_q <= onext_q + 32'd1;
        oidx_q  <= ((oidx_q == SAW'(REORDER_SLOTS - 1)) || (onext_q == 32'hFFFF_FFFF)) ?
                   '0 : oidx_q + SAW'(1);
      end
      if (cmd_i.ver_take) begin
        ver_valid_q[crem] <= 1'b1;
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      it_seq_q     <= pkt_seq_i;
      it_chan_q    <= chan_id_i;
      it_ref_q     <= payload_ref_i;
      it_ver_q     <= version_word_i;
      it_kind_q    <= chan_kind_i;
      pend_kind_q  <= ITEM_STATUS;
      pend_ack_q   <= ack;
      pend_seq_q   <= 32'd0;
      pend_chan_q  <= 8'd0;
      pend_ckind_q <= 2'd0;
      pend_ref_q   <= 16'd0;
    end
    if (cmd_i.drain_take) begin
      pend_kind_q  <= ITEM_EVENT;
      pend_ack_q   <= 1'b0;
      pend_seq_q   <= onext_q;
      pend_chan_q  <= slot_rdata[23:16];
      pend_ckind_q <= CK_ORDERED;
      pend_ref_q   <= slot_rdata[15:0];
    end
    if (cmd_i.ver_take || cmd_i.ev_take) begin
      pend_kind_q  <= ITEM_EVENT;
      pend_ack_q   <= 1'b0;
      pend_seq_q   <= it_seq_q;
      pend_chan_q  <= it_chan_q;
      // unordered and unreliable events keep the packet's own kind
      pend_ckind_q <= cmd_i.ver_take ? CK_MONOTONIC : it_kind_q;
      pend_ref_q   <= it_ref_q;
    end
    if (push) begin
      out_kind_q  <= pend_kind_q;
      out_ack_q   <= pend_ack_q;
      out_seq_q   <= pend_seq_q;
      out_chan_q  <= pend_chan_q;
      out_ckind_q <= pend_ckind_q;
      out_ref_q   <= pend_ref_q;
      out_last_q  <= cmd_i.fin_take;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign item_kind_o         = out_kind_q;
  assign ack_request_o       = out_ack_q;
  assign event_seq_o         = out_seq_q;
  assign event_chan_id_o     = out_chan_q;
  assign event_chan_kind_o   = out_ckind_q;
  assign event_payload_ref_o = out_ref_q;
  assign last_of_run_o       = out_last_q;

endmodule
